FILE: sv/mped_pkg.sv
// Shared types and constants for the mouse packet event decoder.
package mped_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Event type codes.
    localparam logic [1:0] TYPE_BUTTON = 2'd0;
    localparam logic [1:0] TYPE_MOTION = 2'd1;
    localparam logic [1:0] TYPE_SYNC   = 2'd2;

    // Status byte button masks.
    localparam logic [7:0] MASK_LEFT   = 8'h01;
    localparam logic [7:0] MASK_RIGHT  = 8'h02;
    localparam logic [7:0] MASK_MIDDLE = 8'h04;

    typedef enum logic [2:0] {
        CODE_LEFT   = 3'd0,
        CODE_RIGHT  = 3'd1,
        CODE_MIDDLE = 3'd2,
        CODE_X      = 3'd3,
        CODE_Y      = 3'd4,
        CODE_WHEEL  = 3'd5,
        CODE_SYNC   = 3'd6
    } event_code_t;

    // One complete packet as handed from the byte gatherer to the event sequencer.
    typedef struct packed {
        logic       left;
        logic       right;
        logic       middle;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic       wheel;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: sv/mouse_packet_event_decoder.sv
// Top level of the mouse packet event decoder.
//
// Mouse bytes enter one per transfer on the input channel (in_valid, in_stall,
// data_byte). Three bytes make a packet, or four when wheel_mode is 1; the
// mode register is written through its own valid/ready channel, which is
// always ready. Bytes that do not end a packet give no event. The byte that
// ends one is queued as a whole packet, and the sequencer then emits one event
// per transfer on the output channel: left, right and middle button, X, Y and
// wheel motion where nonzero, then a sync event with last_event set.
// The final byte's packet is written into the queue, and its first event is
// then loaded into the output register. A packet gives 4 to 7 events, one
// event per cycle while out_stall is low. Bytes are taken every cycle while
// the packet queue has room; it holds QueueDepth packets, so the next packet
// gathers while one drains. When the receiver stalls, the output register
// holds its event and the queue fills; once full, in_stall rises for every
// byte. Reset clears the byte position, queue, output valid and wheel_mode.
module mouse_packet_event_decoder #(
    parameter int QueueDepth = mped_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wheel_mode_valid,
    output logic              wheel_mode_ready,
    input  logic              wheel_mode,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_type,
    output logic [2:0]        event_code,
    output logic signed [8:0] event_value,
    output logic              last_event
);

    logic                    wheel_mode_reg;
    logic                    push;
    logic                    pop;
    mped_pkg::packet_t       push_data;
    mped_pkg::packet_t       head;
    mped_pkg::queue_status_t q_status;

    assign wheel_mode_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg <= 1'b0;
        end
        else if (wheel_mode_valid && wheel_mode_ready)
        begin
            wheel_mode_reg <= wheel_mode;
        end
    end

    mped_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .wheel_mode (wheel_mode_reg),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    mped_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    mped_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .last_event  (last_event)
    );

endmodule

FILE: sv/mped_front.sv
// Byte gatherer: collects mouse bytes into packets and pushes finished packets.
module mped_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              data_byte,
    input  logic                    wheel_mode,
    input  mped_pkg::queue_status_t q_status,
    output logic                    push,
    output mped_pkg::packet_t       push_data
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] store_reg [3];
    logic [1:0] final_pos;
    logic       in_fire;
    logic       store_wr;

    assign in_stall  = q_status.full;
    assign in_fire   = in_valid && !in_stall;
    assign final_pos = wheel_mode ? 2'd3 : 2'd2;
    assign store_wr  = in_fire && (pos_reg < final_pos);

    always_comb
    begin
        pos_next = pos_reg;
        push     = 1'b0;
        if (in_fire)
        begin
            if (pos_reg < final_pos)
            begin
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                // A stray byte left over after wheel mode was cleared is dropped.
                pos_next = 2'd0;
                push     = (pos_reg == final_pos);
            end
        end
    end

    always_comb
    begin
        push_data.left   = |(store_reg[0] & mped_pkg::MASK_LEFT);
        push_data.right  = |(store_reg[0] & mped_pkg::MASK_RIGHT);
        push_data.middle = |(store_reg[0] & mped_pkg::MASK_MIDDLE);
        push_data.x      = store_reg[1];
        push_data.y      = wheel_mode ? store_reg[2] : data_byte;
        push_data.w      = wheel_mode ? data_byte : 8'd0;
        push_data.wheel  = wheel_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[pos_reg] <= data_byte;
        end
    end

endmodule

FILE: sv/mped_queue.sv
// Small packet queue between the byte gatherer and the event sequencer.
module mped_queue #(
    parameter int Depth = mped_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mped_pkg::packet_t       push_data,
    input  logic                    pop,
    output mped_pkg::packet_t       head,
    output mped_pkg::queue_status_t status
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
    localparam logic [CW-1:0] FullCount = CW'(Depth);

    mped_pkg::packet_t entry_reg [Depth];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == FullCount);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/mped_back.sv
// Event sequencer: walks the head packet and emits one event per transfer.
module mped_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mped_pkg::packet_t       head,
    input  mped_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              event_type,
    output logic [2:0]              event_code,
    output logic signed [8:0]       event_value,
    output logic                    last_event
);

    mped_pkg::event_code_t step_reg;
    mped_pkg::event_code_t step_next;
    logic                  out_valid_reg;
    logic [1:0]            type_reg;
    logic [2:0]            code_reg;
    logic signed [8:0]     value_reg;
    logic                  last_reg;
    logic                  load;
    logic                  x_nz;
    logic                  y_nz;
    logic                  w_nz;
    logic [1:0]            type_now;
    logic signed [8:0]     value_now;

    assign x_nz = (head.x != 8'd0);
    assign y_nz = (head.y != 8'd0);
    assign w_nz = head.wheel && (head.w != 8'd0);

    assign load = (!out_valid_reg || !out_stall) && !q_status.empty;
    assign pop  = load && (step_reg == mped_pkg::CODE_SYNC);

    // Motion events with zero value are skipped, so after the middle button or an
    // axis the next step is the next motion axis that moved, or the sync event.
    always_comb
    begin
        step_next = mped_pkg::CODE_SYNC;
        case (step_reg)
            mped_pkg::CODE_LEFT:   step_next = mped_pkg::CODE_RIGHT;
            mped_pkg::CODE_RIGHT:  step_next = mped_pkg::CODE_MIDDLE;
            mped_pkg::CODE_MIDDLE:
            begin
                if (x_nz)
                    step_next = mped_pkg::CODE_X;
                else if (y_nz)
                    step_next = mped_pkg::CODE_Y;
                else if (w_nz)
                    step_next = mped_pkg::CODE_WHEEL;
                else
                    step_next = mped_pkg::CODE_SYNC;
            end
            mped_pkg::CODE_X:
            begin
                if (y_nz)
                    step_next = mped_pkg::CODE_Y;
                else if (w_nz)
                    step_next = mped_pkg::CODE_WHEEL;
                else
                    step_next = mped_pkg::CODE_SYNC;
            end
            mped_pkg::CODE_Y:
            begin
                if (w_nz)
                    step_next = mped_pkg::CODE_WHEEL;
                else
                    step_next = mped_pkg::CODE_SYNC;
            end
            mped_pkg::CODE_WHEEL:  step_next = mped_pkg::CODE_SYNC;
            mped_pkg::CODE_SYNC:   step_next = mped_pkg::CODE_LEFT;
            default:               step_next = mped_pkg::CODE_LEFT;
        endcase
    end

    always_comb
    begin
        type_now  = mped_pkg::TYPE_SYNC;
        value_now = 9'sd0;
        case (step_reg)
            mped_pkg::CODE_LEFT:
            begin
                type_now  = mped_pkg::TYPE_BUTTON;
                value_now = {8'd0, head.left};
            end
            mped_pkg::CODE_RIGHT:
            begin
                type_now  = mped_pkg::TYPE_BUTTON;
                value_now = {8'd0, head.right};
            end
            mped_pkg::CODE_MIDDLE:
            begin
                type_now  = mped_pkg::TYPE_BUTTON;
                value_now = {8'd0, head.middle};
            end
            mped_pkg::CODE_X:
            begin
                type_now  = mped_pkg::TYPE_MOTION;
                value_now = {head.x[7], head.x};
            end
            mped_pkg::CODE_Y:
            begin
                // Screen Y grows downward, so the mouse's Y is negated.
                type_now  = mped_pkg::TYPE_MOTION;
                value_now = 9'sd0 - $signed({head.y[7], head.y});
            end
            mped_pkg::CODE_WHEEL:
            begin
                type_now  = mped_pkg::TYPE_MOTION;
                value_now = {head.w[7], head.w};
            end
            default:
            begin
                type_now  = mped_pkg::TYPE_SYNC;
                value_now = 9'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= mped_pkg::CODE_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= step_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            type_reg  <= type_now;
            code_reg  <= step_reg;
            value_reg <= value_now;
            last_reg  <= (step_reg == mped_pkg::CODE_SYNC);
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_type  = type_reg;
    assign event_code  = code_reg;
    assign event_value = value_reg;
    assign last_event  = last_reg;

endmodule
